@@ sv/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// BM25 score accumulator package
// Shared constants, codes and types of the score accumulator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int NUM_DOCS_DEF    = 65536;
    localparam int LENGTH_BITS_DEF = 20;
    localparam int SCORE_BITS_DEF  = 48;

    // Field widths of the channels.
    localparam int OP_W        = 2;
    localparam int DOC_W       = 16;
    localparam int TF_W        = 16;
    localparam int DL_W        = 20;
    localparam int SCORE_OUT_W = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int LEN_FIELD_W = 32;

    // Datapath widths.
    localparam int DIV_NW  = 65;
    localparam int DIV_DW  = 57;
    localparam int NORM_W  = 40;
    localparam int CD_W    = 41;
    localparam int F_W     = 22;
    localparam int PROD_W  = 47;
    localparam logic [NORM_W-1:0] NORM_CAP = '1;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [OP_W-1:0] OP_WR_LEN = 2'd0;
    localparam logic [OP_W-1:0] OP_SCORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [1:0] VAR_PLUS = 2'd1;
    localparam logic [1:0] VAR_L    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT  = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [DOC_W-1:0]       doc;
        logic [TF_W-1:0]        tf;
        logic [LEN_FIELD_W-1:0] len;
    } t_item;

    typedef struct packed {
        logic take;
        logic clearing;
    } t_bk_stat;

    typedef struct packed {
        logic [1:0]         variant;
        logic [15:0]        k1;
        logic [16:0]        b;
        logic [23:0]        avg;
        logic [15:0]        delta;
        logic signed [23:0] weight;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_RD,
        ST_NMUL,
        ST_NDIV_GO,
        ST_NDIV_WAIT,
        ST_OMUL,
        ST_ODIV_GO,
        ST_ODIV_WAIT,
        ST_LPRE,
        ST_L1_GO,
        ST_L1_WAIT,
        ST_LMUL,
        ST_L2_GO,
        ST_L2_WAIT,
        ST_WMUL,
        ST_ACC,
        ST_OUT
    } t_state;

endpackage

@@ sv/bsa_if.sv @@
// ----------------------------------------------------------------------------
// BM25 score accumulator channels
// Input item, result and configuration write channels.
// ----------------------------------------------------------------------------
interface bsa_in_if;
    import bsa_pkg::*;
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] opcode;
    logic [DOC_W-1:0] doc_index;
    logic [TF_W-1:0] term_freq;
    logic [DL_W-1:0] doc_length;
    modport source (output valid, opcode, doc_index, term_freq, doc_length, input ready);
    modport sink (input valid, opcode, doc_index, term_freq, doc_length, output ready);
endinterface

interface bsa_out_if;
    import bsa_pkg::*;
    logic                          valid;
    logic                          ready;
    logic [DOC_W-1:0]              doc_out;
    logic signed [SCORE_OUT_W-1:0] score;
    logic                          saturated;
    modport source (output valid, doc_out, score, saturated, input ready);
    modport sink (input valid, doc_out, score, saturated, output ready);
endinterface

interface bsa_cfg_if;
    import bsa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/bsa_div.sv @@
// ----------------------------------------------------------------------------
// BM25 score accumulator divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsa_div #(
    parameter int NW = bsa_pkg::DIV_NW,
    parameter int DW = bsa_pkg::DIV_DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_t;
    logic          w_ge;

    assign w_t  = {r_rem, r_q[NW-1]};
    assign w_ge = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy && r_cnt != '0) begin
            r_q   <= {r_q[NW-2:0], w_ge};
            r_rem <= w_ge ? DW'(w_t - {1'b0, r_den}) : w_t[DW-1:0];
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_q;
endmodule

@@ sv/bsa_front.sv @@
// ----------------------------------------------------------------------------
// BM25 score accumulator front end
// Accepts items, clamps the length and queues them for the back end.
// ----------------------------------------------------------------------------
module bsa_front #(
    parameter int LENGTH_BITS = bsa_pkg::LENGTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bsa_in_if.sink            i_in,
    input  bsa_pkg::t_bk_stat i_stat,
    output logic              o_valid,
    output bsa_pkg::t_item    o_item
);
    import bsa_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);
    localparam logic [32:0] LMAX = (33'd1 << LENGTH_BITS) - 33'd1;

    t_item             r_q_mem [QUEUE_DEPTH];
    logic [QP_W-1:0]   r_wp;
    logic [QP_W-1:0]   r_rp;
    logic [QP_W:0]     r_cnt;
    logic              w_ready;
    logic              w_push;
    logic              w_pop;
    logic [32:0]       w_dl;
    logic [32:0]       w_len;
    t_item             w_item;

    assign w_ready = (r_cnt != (QP_W+1)'(QUEUE_DEPTH)) && !i_stat.clearing;
    assign i_in.ready = w_ready;
    assign w_push = i_in.valid && w_ready;
    assign w_pop  = i_stat.take && (r_cnt != '0);

    // Lengths beyond the table width are held at the largest length.
    assign w_dl  = 33'(i_in.doc_length);
    assign w_len = (w_dl > LMAX) ? LMAX : w_dl;

    always_comb begin
        w_item.op  = i_in.opcode;
        w_item.doc = i_in.doc_index;
        w_item.tf  = i_in.term_freq;
        w_item.len = w_len[LEN_FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QP_W+1)'(w_push) - (QP_W+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_mem[r_wp] <= w_item;
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_item  = r_q_mem[r_rp];
endmodule

@@ sv/bsa_back.sv @@
// ----------------------------------------------------------------------------
// BM25 score accumulator back end
// Sequencer with the length and score tables, shared divider and result register.
// ----------------------------------------------------------------------------
module bsa_back #(
    parameter int NUM_DOCS    = bsa_pkg::NUM_DOCS_DEF,
    parameter int LENGTH_BITS = bsa_pkg::LENGTH_BITS_DEF,
    parameter int SCORE_BITS  = bsa_pkg::SCORE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bsa_pkg::t_item     i_item,
    input  bsa_pkg::t_cfg      i_cfg,
    output bsa_pkg::t_bk_stat  o_stat,
    bsa_out_if.source          o_out
);
    import bsa_pkg::*;

    localparam int AW = $clog2(NUM_DOCS);
    localparam int LW = LENGTH_BITS;
    localparam int SW = SCORE_BITS;
    // The index needs a true remainder only for a table that is neither a
    // power of two deep nor at least as deep as the document number range.
    localparam bit MOD_FREE = ((NUM_DOCS & (NUM_DOCS - 1)) == 0) || (NUM_DOCS >= 65536);
    // Rounded-up reciprocal of the depth; exact for any 16-bit document number.
    localparam logic [32:0] MOD_RECIP =
        33'(((64'd1 << 32) + 64'(NUM_DOCS) - 64'd1) / 64'(NUM_DOCS));

    t_state                r_state;
    t_state                n_state;
    logic                  w_div_start;
    logic                  w_pop;
    logic                  div_done;
    logic [DIV_NW-1:0]     div_quo;

    logic [LW-1:0]         r_len_mem [NUM_DOCS];
    logic [SW-1:0]         r_score_mem [NUM_DOCS];
    logic [AW-1:0]         r_clr;
    logic [AW-1:0]         r_idx;
    logic [OP_W-1:0]       r_op;
    logic [DOC_W-1:0]      r_doc;
    logic [DOC_W-1:0]      r_mq;
    logic [TF_W-1:0]       r_tf;
    logic [LW-1:0]         r_lenw;
    logic [LW-1:0]         r_len;
    logic signed [SW-1:0]  r_score;
    logic [DIV_NW-1:0]     r_a;
    logic [DIV_DW-1:0]     r_d;
    logic [NORM_W-1:0]     r_norm;
    logic [CD_W-1:0]       r_cd;
    logic [F_W-1:0]        r_f;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SW-1:0]  r_result;
    logic                  r_sat;
    logic                  r_ov;
    logic [DOC_W-1:0]      r_out_doc;
    logic signed [SCORE_OUT_W-1:0] r_out_score;
    logic                  r_out_sat;

    logic [31:0]           w_doc32;
    logic [48:0]           w_mprod;
    logic [DOC_W-1:0]      w_midx;
    logic [16:0]           w_bb;
    logic [16:0]           w_kp1;
    logic [19:0]           w_d16;
    logic [16+LW:0]        w_bl;
    logic [DIV_NW:0]       w_nsum;
    logic [NORM_W-1:0]     w_norm;
    logic [32:0]           w_tk;
    logic [55:0]           w_kn;
    logic [F_W-1:0]        w_fo;
    logic [NORM_W-1:0]     w_c;
    logic [57:0]           w_kc;
    logic signed [PROD_W-1:0] w_contrib;
    logic signed [SW:0]    w_sum;
    logic signed [SW-1:0]  w_smax;
    logic signed [SW-1:0]  w_acc;
    logic                  w_ovf;
    logic                  w_load;
    logic                  w_len_we;
    logic                  w_sc_we;
    logic [AW-1:0]         w_sc_addr;
    logic [SW-1:0]         w_sc_data;

    bsa_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_a),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign w_doc32 = 32'(i_item.doc);
    // The index is reduced modulo the depth by a reciprocal multiplication.
    assign w_mprod = 49'(r_doc) * 49'(MOD_RECIP);
    assign w_midx  = DOC_W'(32'(r_doc) - 32'(r_mq) * 32'(NUM_DOCS));
    assign w_bb    = (i_cfg.b > 17'd65536) ? 17'd65536 : i_cfg.b;
    assign w_kp1   = 17'(i_cfg.k1) + 17'd4096;
    assign w_d16   = {i_cfg.delta, 4'd0};
    assign w_bl    = w_bb * r_len;
    assign w_nsum  = (DIV_NW+1)'(div_quo) + (DIV_NW+1)'(17'd65536 - w_bb);
    assign w_norm  = (w_nsum > (DIV_NW+1)'(NORM_CAP)) ? NORM_CAP : w_nsum[NORM_W-1:0];
    assign w_tk    = r_tf * w_kp1;
    assign w_kn    = i_cfg.k1 * r_norm;
    assign w_fo    = (r_d == '0) ? '0 : div_quo[F_W-1:0];
    assign w_kc    = w_kp1 * r_cd;

    // A zero norm makes the scaled frequency the cap whenever tf is nonzero.
    always_comb begin
        if (r_norm == '0) begin
            w_c = (r_tf != '0) ? NORM_CAP : '0;
        end else if (div_quo > DIV_NW'(NORM_CAP)) begin
            w_c = NORM_CAP;
        end else begin
            w_c = div_quo[NORM_W-1:0];
        end
    end

    // Arithmetic shift floors the weighted factor towards minus infinity.
    assign w_contrib = r_prod >>> 16;
    assign w_sum     = (SW+1)'(r_score) + (SW+1)'(w_contrib);
    assign w_ovf     = w_sum[SW] != w_sum[SW-1];
    assign w_smax    = {1'b0, {(SW-1){1'b1}}};
    assign w_acc     = w_ovf ? (w_sum[SW] ? ~w_smax : w_smax) : w_sum[SW-1:0];

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_pop       = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(NUM_DOCS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                w_pop = i_valid;
                if (i_valid) begin
                    n_state = MOD_FREE ? ST_RD : ST_MOD_GO;
                end
            end
            ST_MOD_GO: begin
                n_state = ST_MOD_WAIT;
            end
            ST_MOD_WAIT: begin
                n_state = ST_RD;
            end
            ST_RD: begin
                n_state = (r_op == OP_SCORE) ? ST_NMUL : ST_ACC;
            end
            ST_NMUL: begin
                n_state = ST_NDIV_GO;
            end
            ST_NDIV_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_NDIV_WAIT;
            end
            ST_NDIV_WAIT: begin
                if (div_done) begin
                    n_state = (i_cfg.variant == VAR_L) ? ST_LPRE : ST_OMUL;
                end
            end
            ST_OMUL: begin
                n_state = ST_ODIV_GO;
            end
            ST_ODIV_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_ODIV_WAIT;
            end
            ST_ODIV_WAIT: begin
                if (div_done) begin
                    n_state = ST_WMUL;
                end
            end
            ST_LPRE: begin
                n_state = ST_L1_GO;
            end
            ST_L1_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_L1_WAIT;
            end
            ST_L1_WAIT: begin
                if (div_done) begin
                    n_state = ST_LMUL;
                end
            end
            ST_LMUL: begin
                n_state = ST_L2_GO;
            end
            ST_L2_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_L2_WAIT;
            end
            ST_L2_WAIT: begin
                if (div_done) begin
                    n_state = ST_WMUL;
                end
            end
            ST_WMUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ov || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_op   <= i_item.op;
                    r_doc  <= i_item.doc;
                    r_tf   <= i_item.tf;
                    r_lenw <= i_item.len[LW-1:0];
                    r_idx  <= w_doc32[AW-1:0];
                end
            end
            ST_MOD_GO: begin
                r_mq <= w_mprod[47:32];
            end
            ST_MOD_WAIT: begin
                r_idx <= AW'(w_midx);
            end
            ST_NMUL: begin
                r_a <= DIV_NW'({w_bl, 4'd0});
                r_d <= (i_cfg.avg == '0) ? DIV_DW'(1) : DIV_DW'(i_cfg.avg);
            end
            ST_NDIV_WAIT: begin
                if (div_done) begin
                    r_norm <= w_norm;
                end
            end
            ST_OMUL: begin
                r_a <= DIV_NW'({w_tk, 32'd0});
                r_d <= DIV_DW'(w_kn) + DIV_DW'({r_tf, 28'd0});
            end
            ST_ODIV_WAIT: begin
                if (div_done) begin
                    r_f <= (i_cfg.variant == VAR_PLUS) ? w_fo + F_W'(w_d16) : w_fo;
                end
            end
            ST_LPRE: begin
                r_a <= DIV_NW'({r_tf, 32'd0});
                r_d <= DIV_DW'(r_norm);
            end
            ST_L1_WAIT: begin
                if (div_done) begin
                    r_cd <= CD_W'(w_c) + CD_W'(w_d16);
                end
            end
            ST_LMUL: begin
                r_a <= DIV_NW'({w_kc, 4'd0});
                r_d <= DIV_DW'(r_cd) + DIV_DW'({i_cfg.k1, 4'd0});
            end
            ST_L2_WAIT: begin
                if (div_done) begin
                    r_f <= w_fo;
                end
            end
            ST_WMUL: begin
                r_prod <= i_cfg.weight * $signed({1'b0, r_f});
            end
            ST_ACC: begin
                case (r_op)
                    OP_SCORE: begin
                        r_result <= w_acc;
                        r_sat    <= w_ovf;
                    end
                    OP_READ: begin
                        r_result <= r_score;
                        r_sat    <= 1'b0;
                    end
                    default: begin
                        r_result <= '0;
                        r_sat    <= 1'b0;
                    end
                endcase
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_out_doc   <= r_doc;
            r_out_score <= SCORE_OUT_W'(r_result);
            r_out_sat   <= r_sat;
        end
    end

    // Table ports: the score table is swept to zero after reset.
    assign w_len_we  = (r_state == ST_ACC) && (r_op == OP_WR_LEN);
    assign w_sc_we   = (r_state == ST_CLEAR) ||
                       ((r_state == ST_ACC) && ((r_op == OP_SCORE) || (r_op == OP_READ)));
    assign w_sc_addr = (r_state == ST_CLEAR) ? r_clr : r_idx;
    assign w_sc_data = ((r_state == ST_ACC) && (r_op == OP_SCORE)) ? w_acc : '0;

    always_ff @(posedge i_clk) begin
        if (w_len_we) begin
            r_len_mem[r_idx] <= r_lenw;
        end
        r_len <= r_len_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_sc_we) begin
            r_score_mem[w_sc_addr] <= w_sc_data;
        end
        r_score <= r_score_mem[r_idx];
    end

    assign o_stat.take     = w_pop;
    assign o_stat.clearing = r_state == ST_CLEAR;

    assign o_out.valid     = r_ov;
    assign o_out.doc_out   = r_out_doc;
    assign o_out.score     = r_out_score;
    assign o_out.saturated = r_out_sat;
endmodule

@@ sv/bm25_score_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// BM25 score accumulator
// Okapi, BM25+ and BM25L posting scorer with per-document score table.
// A length write, a score read or an idle opcode uses no division; an Okapi
// or BM25+ posting takes two passes through the shared bit-serial divider and
// a BM25L posting three. A table that is neither a power of two deep nor at
// least 65536 deep adds a remainder step for the index.
// One item is worked at a time, and the back end waits while a result is held.
// After reset the score table is cleared entry by entry before items
// are taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module bm25_score_accumulator_unit #(
    parameter int NUM_DOCS    = bsa_pkg::NUM_DOCS_DEF,
    parameter int LENGTH_BITS = bsa_pkg::LENGTH_BITS_DEF,
    parameter int SCORE_BITS  = bsa_pkg::SCORE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsa_in_if.sink     i_in,
    bsa_out_if.source  o_out,
    bsa_cfg_if.sink    i_cfg
);
    import bsa_pkg::*;

    t_cfg     r_cfg;
    t_item    q_item;
    logic     q_valid;
    t_bk_stat bk_stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.variant <= 2'd0;
            r_cfg.k1      <= 16'd4915;
            r_cfg.b       <= 17'd49152;
            r_cfg.avg     <= 24'd1600;
            r_cfg.delta   <= 16'd4096;
            r_cfg.weight  <= 24'sd65536;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_VARIANT: r_cfg.variant <= i_cfg.data[1:0];
                CFG_K1:      r_cfg.k1      <= i_cfg.data[15:0];
                CFG_B:       r_cfg.b       <= i_cfg.data[16:0];
                CFG_AVG:     r_cfg.avg     <= i_cfg.data;
                CFG_DELTA:   r_cfg.delta   <= i_cfg.data[15:0];
                CFG_WEIGHT:  r_cfg.weight  <= $signed(i_cfg.data);
                default: begin
                end
            endcase
        end
    end

    bsa_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (bk_stat),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    bsa_back #(
        .NUM_DOCS    (NUM_DOCS),
        .LENGTH_BITS (LENGTH_BITS),
        .SCORE_BITS  (SCORE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .i_cfg   (r_cfg),
        .o_stat  (bk_stat),
        .o_out   (o_out)
    );
endmodule

@@ sim/bm25_score_accumulator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// BM25 score accumulator testbench
// Drives a directed table, then phases of random postings, length writes
// and score reads under several register settings. Every result word is
// checked field by field against a bench scoring model or a typed table row.
// ----------------------------------------------------------------------------
module bm25_score_accumulator_unit_tb;
    import bsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_NONE      = 2'd3;
    localparam logic [1:0]      VAR_OKAPI    = 2'd0;
    localparam logic [1:0]      VAR_SPARE    = 2'd3;
    localparam int              N_PHASES     = 8;
    localparam int              PHASE_ITEMS  = 165;
    localparam int              DRAIN_CYCLES = 400;
    localparam int              HOLD_CYCLES  = 3000;
    localparam longint          CYCLE_LIMIT  = 4000000;
    localparam logic [63:0]     CAP40        = (64'd1 << 40) - 64'd1;
    localparam longint          SMAX         = (64'sd1 <<< 47) - 64'sd1;
    localparam longint          SMIN         = -SMAX - 64'sd1;

    typedef struct packed {
        logic [DOC_W-1:0]       doc;
        logic [SCORE_OUT_W-1:0] score;
        logic                   sat;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [DOC_W-1:0]       doc;
        logic [TF_W-1:0]        tf;
        logic [DL_W-1:0]        len;
        logic                   typed;
        logic [SCORE_OUT_W-1:0] score;
        logic                   sat;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;

    bsa_in_if  in_ch ();
    bsa_out_if out_ch ();
    bsa_cfg_if cfg_ch ();

    bm25_score_accumulator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Bench copy of the registers and tables.
    logic [1:0]  m_variant;
    logic [15:0] m_k1;
    logic [16:0] m_b;
    logic [23:0] m_avg;
    logic [15:0] m_delta;
    logic [23:0] m_weight;
    logic [19:0] len_tab [int];
    longint      score_tab [int];

    result_t pending_scores [$];
    int      errors = 0;
    int      burst_left = 0;
    bit      gaps_on = 1;
    bit      hold_req = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [63:0] posting_factor(input logic [63:0] tf,
                                                   input logic [63:0] len);
        logic [63:0]  bb, avg, norm, kp1, d16, c, cd, den;
        logic [127:0] q;
        bb   = (m_b > 17'd65536) ? 64'd65536 : 64'(m_b);
        avg  = (m_avg == 0) ? 64'd1 : 64'(m_avg);
        norm = (64'd65536 - bb) + (bb * len * 64'd16) / avg;
        kp1  = 64'(m_k1) + 64'd4096;
        d16  = 64'(m_delta) << 4;
        if (norm > CAP40) norm = CAP40;
        if (m_variant == VAR_L) begin
            if (norm == 0) c = (tf != 0) ? CAP40 : 64'd0;
            else c = (tf << 32) / norm;
            if (c > CAP40) c = CAP40;
            cd  = c + d16;
            den = (64'(m_k1) << 4) + cd;
            if (den == 0) return 64'd0;
            q = (128'(kp1 * cd) << 4) / 128'(den);
            return q[63:0];
        end
        den = (tf << 28) + 64'(m_k1) * norm;
        if (den == 0) q = '0;
        else q = (128'(tf * kp1) << 32) / 128'(den);
        if (m_variant == VAR_PLUS) q = q + 128'(d16);
        return q[63:0];
    endfunction

    function automatic result_t predict_item(input logic [OP_W-1:0] op,
                                             input logic [DOC_W-1:0] doc,
                                             input logic [TF_W-1:0] tf,
                                             input logic [DL_W-1:0] len);
        result_t r;
        longint  w, p, contrib, s;
        int      idx;
        idx = int'(doc);
        r.doc = doc;
        r.score = '0;
        r.sat = 1'b0;
        s = score_tab.exists(idx) ? score_tab[idx] : 0;
        case (op)
            OP_WR_LEN: len_tab[idx] = len;
            OP_SCORE: begin
                w = longint'($signed(m_weight));
                p = w * longint'(posting_factor(64'(tf), 64'(len_tab[idx])));
                contrib = p >>> 16;
                if (contrib > 0 && s > SMAX - contrib) begin
                    s = SMAX;
                    r.sat = 1'b1;
                end else if (contrib < 0 && s < SMIN - contrib) begin
                    s = SMIN;
                    r.sat = 1'b1;
                end else begin
                    s = s + contrib;
                end
                score_tab[idx] = s;
                r.score = s[SCORE_OUT_W-1:0];
            end
            OP_READ: begin
                r.score = s[SCORE_OUT_W-1:0];
                score_tab[idx] = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [DOC_W-1:0] doc,
                             input logic [TF_W-1:0] tf, input logic [DL_W-1:0] len,
                             input logic typed, input logic [SCORE_OUT_W-1:0] t_score,
                             input logic t_sat);
        result_t r;
        if (burst_left == 0) begin
            if (gaps_on) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 25);
        end
        burst_left--;
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.doc_index  <= doc;
        in_ch.term_freq  <= tf;
        in_ch.doc_length <= len;
        do @(posedge i_clk); while (!in_ch.ready);
        r = predict_item(op, doc, tf, len);
        if (typed) begin
            r.score = t_score;
            r.sat   = t_sat;
        end
        pending_scores.push_back(r);
    endtask

    // Valid stays high across a run of writes and is dropped by the caller.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_VARIANT: m_variant = data[1:0];
            CFG_K1:      m_k1      = data[15:0];
            CFG_B:       m_b       = data[16:0];
            CFG_AVG:     m_avg     = data;
            CFG_DELTA:   m_delta   = data[15:0];
            CFG_WEIGHT:  m_weight  = data;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_phase(input int ph);
        logic [23:0] v [6];
        v[0] = 24'($urandom_range(0, 3));
        v[1] = 24'($urandom_range(0, 65535));
        v[2] = 24'($urandom_range(0, 131071));
        v[3] = $urandom_range(0, 1) ? 24'($urandom_range(16, 4096)) : 24'($urandom);
        v[4] = 24'($urandom_range(0, 65535));
        v[5] = 24'($urandom);
        case (ph)
            0: v = '{24'(VAR_OKAPI), 24'd4915, 24'd49152, 24'd1600, 24'd4096, 24'd65536};
            1: v = '{24'(VAR_OKAPI), 24'd0, 24'd0, 24'd16, 24'd0, 24'h800000};
            2: v = '{24'(VAR_PLUS), 24'd65535, 24'd65536, 24'hFFFFFF, 24'd65535,
                     24'h7FFFFF};
            // b of one and empty documents give a zero norm for BM25L.
            3: v = '{24'(VAR_L), 24'd65535, 24'd65536, 24'd16, 24'd65535, 24'h7FFFFF};
            4: begin
                v[0] = 24'(VAR_SPARE);
                v[2] = 24'd131071;
                v[3] = 24'd0;
            end
            default: ;
        endcase
        write_reg(CFG_VARIANT, v[0]);
        write_reg(CFG_K1, v[1]);
        write_reg(CFG_B, v[2]);
        write_reg(CFG_AVG, v[3]);
        write_reg(CFG_DELTA, v[4]);
        write_reg(CFG_WEIGHT, v[5]);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_item();
        logic [DOC_W-1:0] doc;
        logic [TF_W-1:0]  tf;
        logic [DL_W-1:0]  len;
        logic [OP_W-1:0]  op;
        int               sel;
        sel = $urandom_range(0, 7);
        doc = (sel < 6) ? 16'($urandom_range(0, 15)) :
              (sel == 6) ? ($urandom_range(0, 1) ? 16'd0 : 16'hFFFF) : 16'($urandom);
        sel = $urandom_range(0, 7);
        len = (sel == 0) ? 20'd0 : (sel == 1) ? 20'hFFFFF :
              (sel < 5) ? 20'($urandom_range(1, 4000)) : 20'($urandom);
        sel = $urandom_range(0, 7);
        tf  = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF :
              (sel < 6) ? 16'($urandom_range(1, 20)) : 16'($urandom);
        sel = $urandom_range(0, 19);
        op  = (sel < 4) ? OP_WR_LEN : (sel < 16) ? OP_SCORE : (sel < 19) ? OP_READ : OP_NONE;
        // A posting needs a stored length, so write one first.
        if (op == OP_SCORE && !len_tab.exists(int'(doc)))
            send_item(OP_WR_LEN, doc, tf, len, 1'b0, '0, 1'b0);
        send_item(op, doc, tf, len, 1'b0, '0, 1'b0);
    endtask

    dir_row_t dir_tab [13] = '{
        '{OP_READ,   16'd5,     16'd0,     20'd0,       1'b1, 48'd0, 1'b0},
        '{OP_WR_LEN, 16'd0,     16'd0,     20'd0,       1'b1, 48'd0, 1'b0},
        '{OP_WR_LEN, 16'hFFFF,  16'hFFFF,  20'hFFFFF,   1'b1, 48'd0, 1'b0},
        '{OP_SCORE,  16'd0,     16'd0,     20'd0,       1'b0, 48'd0, 1'b0},
        '{OP_SCORE,  16'd0,     16'hFFFF,  20'd0,       1'b0, 48'd0, 1'b0},
        '{OP_SCORE,  16'hFFFF,  16'd1,     20'hFFFFF,   1'b0, 48'd0, 1'b0},
        '{OP_SCORE,  16'hFFFF,  16'hFFFF,  20'd0,       1'b0, 48'd0, 1'b0},
        '{OP_NONE,   16'd1234,  16'hFFFF,  20'hFFFFF,   1'b1, 48'd0, 1'b0},
        '{OP_READ,   16'd0,     16'd0,     20'd0,       1'b0, 48'd0, 1'b0},
        '{OP_READ,   16'd0,     16'd0,     20'd0,       1'b1, 48'd0, 1'b0},
        '{OP_WR_LEN, 16'd7,     16'd0,     20'd1,       1'b1, 48'd0, 1'b0},
        '{OP_SCORE,  16'd7,     16'd3,     20'd0,       1'b0, 48'd0, 1'b0},
        '{OP_READ,   16'hFFFF,  16'd0,     20'd0,       1'b0, 48'd0, 1'b0}
    };

    // Result checker.
    always @(posedge i_clk) begin : check_results
        result_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_scores.size() == 0) begin
                report("unexpected result word, doc", longint'(out_ch.doc_out), -1);
            end else begin
                e = pending_scores.pop_front();
                if (out_ch.doc_out !== e.doc)
                    report("doc_out", longint'(out_ch.doc_out), longint'(e.doc));
                if (out_ch.score !== e.score)
                    report("score", longint'(out_ch.score), longint'($signed(e.score)));
                if (out_ch.saturated !== e.sat)
                    report("saturated", longint'(out_ch.saturated), longint'(e.sat));
            end
        end
    end

    // Receiver: random stalls in randomly chosen moods, plus one long hold-off.
    initial begin : receiver
        int  mood_left;
        int  hold_left;
        bit  hold_done;
        bit  stall_mood;
        mood_left  = 0;
        hold_left  = 0;
        hold_done  = 0;
        stall_mood = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (mood_left == 0) begin
                mood_left  = $urandom_range(50, 600);
                stall_mood = $urandom_range(0, 1);
            end
            mood_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= stall_mood ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end
    end

    initial begin : watchdog
        longint cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : stimulus
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_WR_LEN;
        in_ch.doc_index  = '0;
        in_ch.term_freq  = '0;
        in_ch.doc_length = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_VARIANT;
        cfg_ch.data      = '0;
        m_variant = VAR_OKAPI;
        m_k1      = 16'd4915;
        m_b       = 17'd49152;
        m_avg     = 24'd1600;
        m_delta   = 16'd4096;
        m_weight  = 24'd65536;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].op, dir_tab[i].doc, dir_tab[i].tf, dir_tab[i].len,
                      dir_tab[i].typed, dir_tab[i].score, dir_tab[i].sat);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_phase(ph);
            gaps_on  = (ph != 5);
            hold_req = (ph >= 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
            drain();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
